// ----- rtl/lzwc_pkg.sv -----
package lzwc_pkg;

    localparam int CODE_W     = 12;
    localparam int DICT_CODES = 1 << CODE_W;
    localparam int BYTE_W     = 8;
    localparam int FIRST_CODE = 256;
    // hash table has twice as many slots as codes
    localparam int SLOT_W     = CODE_W + 1;
    localparam int SLOTS      = 1 << SLOT_W;
    localparam int OUT_TDATA_W = ((CODE_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SLOT,
        S_DICT,
        S_MISS,
        S_LAST
    } t_state;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last;
    } t_beat;

    // dictionary entry: the pair and the slot that points at it
    typedef struct packed {
        logic [CODE_W-1:0] prefix;
        logic [BYTE_W-1:0] byte_val;
        logic [SLOT_W-1:0] slot;
    } t_entry;

    function automatic logic [SLOT_W-1:0] hash(input logic [CODE_W-1:0] prefix,
                                              input logic [BYTE_W-1:0] byte_val);
        logic [SLOT_W-1:0] h;
        h = {1'b0, prefix} ^ {byte_val, {(SLOT_W-BYTE_W){1'b0}}}
            ^ {{(SLOT_W-BYTE_W){1'b0}}, byte_val};
        return h;
    endfunction

endpackage

// ----- rtl/lzwc_out_q.sv -----
// two-entry output queue
module lzwc_out_q (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  lzwc_pkg::t_beat                     i_beat,
    output logic                                o_full,
    output logic                                o_tvalid,
    input  logic                                i_tready,
    output logic [lzwc_pkg::OUT_TDATA_W-1:0]    o_tdata,
    output logic                                o_tlast
);

    lzwc_pkg::t_beat r_mem [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic            pop;

    assign o_full   = (r_cnt == 2'd2);
    assign o_tvalid = (r_cnt != 2'd0);
    assign pop      = o_tvalid && i_tready;
    assign o_tdata  = {{(lzwc_pkg::OUT_TDATA_W-lzwc_pkg::CODE_W){1'b0}}, r_mem[r_rp].code};
    assign o_tlast  = r_mem[r_rp].last;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_beat;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- rtl/lzw_compressor_12bit_core.sv -----
// Channel  Dir  tdata                         tuser  tlast
// s_axis   in   [7:0] data_byte               -      end_of_stream
// m_axis   out  [11:0] code_out, [15:12] zero -      last_code
//
// A byte that starts a stream is only held as the prefix. Any other byte is
// accepted, then looked up by hash probes, each a slot memory read, then a
// dictionary memory read. Every emitted code is pushed from S_MISS or S_LAST.
// After reset the slot memory is cleared, one slot a cycle, all 8192 slots with
// s_axis_tready low. The two-entry output queue holds results while m_axis
// stalls; the block waits only when it must push into a full queue.
module lzw_compressor_12bit_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [11:0] code_out, [15:12] zero
    output logic        m_axis_tlast
);

    localparam int CW = lzwc_pkg::CODE_W;
    localparam int SW = lzwc_pkg::SLOT_W;
    localparam int BW = lzwc_pkg::BYTE_W;

    lzwc_pkg::t_state r_state, n_state;

    // hash slots hold a code; the dictionary, indexed by code, holds the pair
    logic [CW-1:0]     slot_mem [lzwc_pkg::SLOTS];
    lzwc_pkg::t_entry  dict_mem [lzwc_pkg::DICT_CODES];

    logic [BW-1:0] r_byte;
    logic          r_eos;
    logic [CW-1:0] r_prefix;
    logic          r_held;
    logic [CW:0]   r_next;      // next free code, reaches DICT_CODES when full
    logic [SW-1:0] r_idx;       // slot being probed
    logic [SW-1:0] r_clr;
    logic [CW-1:0] r_scode;     // slot read data
    lzwc_pkg::t_entry r_dent;   // dictionary read data

    logic          accept;
    logic          slot_rd;
    logic [SW-1:0] slot_ra;
    logic          slot_we;
    logic [SW-1:0] slot_wa;
    logic [CW-1:0] slot_wd;
    logic          dict_we;
    logic          in_range;
    logic          occupied;
    logic          hit;
    logic          q_full;
    logic          q_push;
    lzwc_pkg::t_beat q_beat;
    logic          dict_room;

    assign accept = s_axis_tvalid && s_axis_tready;

    // slot is live only if its code was handed out this stream and points back
    assign in_range  = (r_scode >= CW'(lzwc_pkg::FIRST_CODE)) && ({1'b0, r_scode} < r_next);
    assign occupied  = in_range && (r_dent.slot == r_idx);
    assign hit       = occupied && (r_dent.prefix == r_prefix) && (r_dent.byte_val == r_byte);
    assign dict_room = (r_next < (CW+1)'(lzwc_pkg::DICT_CODES));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lzwc_pkg::S_CLEAR: begin
                if (r_clr == {SW{1'b1}}) begin
                    n_state = lzwc_pkg::S_IDLE;
                end
            end
            lzwc_pkg::S_IDLE: begin
                if (accept) begin
                    if (!r_held) begin
                        n_state = s_axis_tlast ? lzwc_pkg::S_LAST : lzwc_pkg::S_IDLE;
                    end else begin
                        n_state = lzwc_pkg::S_SLOT;
                    end
                end
            end
            lzwc_pkg::S_SLOT: n_state = lzwc_pkg::S_DICT;
            lzwc_pkg::S_DICT: begin
                if (hit) begin
                    n_state = r_eos ? lzwc_pkg::S_LAST : lzwc_pkg::S_IDLE;
                end else if (occupied) begin
                    n_state = lzwc_pkg::S_SLOT;
                end else begin
                    n_state = lzwc_pkg::S_MISS;
                end
            end
            lzwc_pkg::S_MISS: begin
                if (!q_full) begin
                    n_state = r_eos ? lzwc_pkg::S_LAST : lzwc_pkg::S_IDLE;
                end
            end
            lzwc_pkg::S_LAST: begin
                if (!q_full) begin
                    n_state = lzwc_pkg::S_IDLE;
                end
            end
            default: n_state = lzwc_pkg::S_CLEAR;
        endcase
    end

    // outputs and memory controls
    always_comb begin
        s_axis_tready = 1'b0;
        slot_rd = 1'b0;
        slot_ra = r_idx;
        slot_we = 1'b0;
        slot_wa = r_idx;
        slot_wd = r_next[CW-1:0];
        dict_we = 1'b0;
        q_push  = 1'b0;
        q_beat.code = r_prefix;
        q_beat.last = 1'b0;
        case (r_state)
            lzwc_pkg::S_CLEAR: begin
                slot_we = 1'b1;
                slot_wa = r_clr;
                slot_wd = '0;
            end
            lzwc_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                slot_rd = accept && r_held;
                slot_ra = lzwc_pkg::hash(r_prefix, s_axis_tdata);
            end
            lzwc_pkg::S_DICT: begin
                slot_rd = occupied && !hit;
                slot_ra = r_idx + SW'(1);
            end
            lzwc_pkg::S_MISS: begin
                q_push  = !q_full;
                slot_we = !q_full && dict_room;
                dict_we = !q_full && dict_room;
            end
            lzwc_pkg::S_LAST: begin
                q_push = !q_full;
                q_beat.last = 1'b1;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // memories: registered reads
    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            slot_mem[slot_wa] <= slot_wd;
        end
        if (slot_rd) begin
            r_scode <= slot_mem[slot_ra];
        end
        if (dict_we) begin
            dict_mem[r_next[CW-1:0]] <= '{prefix: r_prefix, byte_val: r_byte, slot: r_idx};
        end
        if (r_state == lzwc_pkg::S_SLOT) begin
            r_dent <= dict_mem[r_scode];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= s_axis_tdata;
            r_eos  <= s_axis_tlast;
        end
        if (slot_rd) begin
            r_idx <= slot_ra;
        end
        if (!i_rst_n) begin
            r_state  <= lzwc_pkg::S_CLEAR;
            r_clr    <= '0;
            r_prefix <= '0;
            r_held   <= 1'b0;
            r_next   <= (CW+1)'(lzwc_pkg::FIRST_CODE);
        end else begin
            r_state <= n_state;
            if (r_state == lzwc_pkg::S_CLEAR) begin
                r_clr <= r_clr + SW'(1);
            end
            if (accept && !r_held) begin
                r_prefix <= {{(CW-BW){1'b0}}, s_axis_tdata};
                r_held   <= 1'b1;
            end
            if (r_state == lzwc_pkg::S_DICT && hit) begin
                r_prefix <= r_scode;
            end
            if (r_state == lzwc_pkg::S_MISS && !q_full) begin
                r_prefix <= {{(CW-BW){1'b0}}, r_byte};
                if (dict_room) begin
                    r_next <= r_next + (CW+1)'(1);
                end
            end
            if (r_state == lzwc_pkg::S_LAST && !q_full) begin
                r_prefix <= '0;
                r_held   <= 1'b0;
                r_next   <= (CW+1)'(lzwc_pkg::FIRST_CODE);
            end
        end
    end

    lzwc_out_q u_out_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_beat   (q_beat),
        .o_full   (q_full),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;

    localparam int CODE_W     = lzwc_pkg::CODE_W;
    localparam int FIRST_CODE = lzwc_pkg::FIRST_CODE;
    localparam int DICT_CODES = lzwc_pkg::DICT_CODES;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic        s_axis_tlast;   // end_of_stream
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [11:0] code_out, [15:12] zero
    logic        m_axis_tlast;   // last_code

    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       eos;
    } t_byte_beat;

    lzw_compressor_12bit_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Encoder shadow: pairs stored per code, searched lowest code first.
    logic [CODE_W-1:0] pair_prefix [FIRST_CODE:DICT_CODES-1];
    logic [7:0]        pair_byte   [FIRST_CODE:DICT_CODES-1];
    int                free_code   = FIRST_CODE;
    logic [CODE_W-1:0] held_code   = '0;
    bit                have_prefix = 1'b0;

    lzwc_pkg::t_beat code_q[$];     // codes still to come out
    t_byte_beat      byte_q[$];     // bytes waiting for the driver
    int         n_err;
    int         cycle_cnt;
    int         hold_cnt;       // long receiver hold-off
    bit         hold_used;

    task automatic encode_byte(input t_byte_beat b);
        int hit;
        hit = -1;
        if (!have_prefix) begin
            held_code   = CODE_W'(b.data_byte);
            have_prefix = 1'b1;
        end else begin
            for (int c = FIRST_CODE; c < free_code; c++) begin
                if (pair_prefix[c] == held_code && pair_byte[c] == b.data_byte) begin
                    hit = c;
                    break;
                end
            end
            if (hit >= 0) begin
                held_code = CODE_W'(hit);
            end else begin
                code_q.push_back('{code: held_code, last: 1'b0});
                if (free_code < DICT_CODES) begin
                    pair_prefix[free_code] = held_code;
                    pair_byte[free_code]   = b.data_byte;
                    free_code++;
                end
                held_code = CODE_W'(b.data_byte);
            end
        end
        if (b.eos) begin
            code_q.push_back('{code: held_code, last: 1'b1});
            free_code   = FIRST_CODE;
            held_code   = '0;
            have_prefix = 1'b0;
        end
    endtask

    function automatic void add_stream(input int len, input int alpha, input int base);
        for (int k = 0; k < len; k++)
            byte_q.push_back('{data_byte: 8'(base + $urandom_range(0, alpha - 1)),
                               eos: (k == len - 1)});
    endfunction

    // Sender: bursts with random gaps; holds while a drain pause is requested.
    int  burst_left;
    int  gap_left;
    bit  drain_req;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
            burst_left    <= 0;
            gap_left      <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                encode_byte('{data_byte: s_axis_tdata, eos: s_axis_tlast});
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (byte_q.size() != 0 && !drain_req && gap_left == 0) begin
                    t_byte_beat b;
                    b = byte_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= b.data_byte;
                    s_axis_tlast  <= b.eos;
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                    if (gap_left != 0)
                        gap_left <= gap_left - 1;
                end
            end
        end
    end

    // Long receiver hold-off, started once the first code shows up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt  <= 0;
            hold_used <= 1'b0;
        end else if (!hold_used && m_axis_tvalid) begin
            hold_cnt  <= 3000;
            hold_used <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // Receiver: own stall pattern, gated by the hold-off.
    int stall_mode;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_mode    <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                lzwc_pkg::t_beat want;
                if (code_q.size() == 0) begin
                    $error("code with none expected: %0d", m_axis_tdata[11:0]);
                    n_err++;
                end else begin
                    want = code_q.pop_front();
                    if (m_axis_tdata[11:0] != want.code) begin
                        $error("code_out exp %0d got %0d", want.code, m_axis_tdata[11:0]);
                        n_err++;
                    end
                    if (m_axis_tlast != want.last) begin
                        $error("last_code exp %0d got %0d", want.last, m_axis_tlast);
                        n_err++;
                    end
                    if (m_axis_tdata[15:12] != 4'd0) begin
                        $error("pad exp 0 got %0h", m_axis_tdata[15:12]);
                        n_err++;
                    end
                end
            end
            if ((cycle_cnt & 1023) == 0)
                stall_mode <= $urandom_range(0, 3);
            if (hold_cnt > 0)
                m_axis_tready <= 1'b0;
            else case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= cycle_cnt[2];
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int streams;
        drain_req = 1'b0;
        i_rst_n   = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: lone last byte, extremes, miss on final byte, repeats.
        byte_q.push_back('{data_byte: 8'h00, eos: 1'b1});
        byte_q.push_back('{data_byte: 8'hFF, eos: 1'b1});
        byte_q.push_back('{data_byte: 8'h00, eos: 1'b0});
        byte_q.push_back('{data_byte: 8'hFF, eos: 1'b1});
        for (int k = 0; k < 10; k++)
            byte_q.push_back('{data_byte: 8'h41, eos: (k == 9)});
        for (int k = 0; k < 8; k++)
            byte_q.push_back('{data_byte: (k[0] ? 8'hAA : 8'h55), eos: (k == 7)});

        // Sender keeps offering these through the receiver hold-off.
        add_stream(60, 4, 0);
        wait (byte_q.size() == 0 && cycle_cnt > 0);

        // Pause until every expected code has arrived.
        drain_req = 1'b1;
        @(posedge i_clk);
        while (s_axis_tvalid) @(posedge i_clk);
        wait (code_q.size() == 0);
        repeat (20) @(posedge i_clk);
        drain_req = 1'b0;

        streams = 0;
        while (streams < 1800) begin
            int len;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 60);
            case ($urandom_range(0, 2))
                0: add_stream(len, 2, $urandom_range(0, 254));
                1: add_stream(len, 8, $urandom_range(0, 248));
                default: add_stream(len, 256, 0);
            endcase
            streams += len;
            wait (byte_q.size() < 50);
        end
        wait (byte_q.size() == 0);
        @(posedge i_clk);
        while (s_axis_tvalid) @(posedge i_clk);
        wait (code_q.size() == 0);
        repeat (50) @(posedge i_clk);
        if (n_err == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
